### rtl/assert_macros.svh
// Assertion macros shared by the keyed table store RTL.
// No dependencies; define SYNTH to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define KTS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("keyed table store assertion failed");
`define KTS_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("keyed table store forbidden condition");
`else
`define KTS_ASSERT(lbl, clk, rst, prop)
`define KTS_NEVER(lbl, clk, rst, expr)
`endif
`endif

### rtl/kts_pkg.sv
// Shared constants, codes and controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps

package kts_pkg;

  localparam int MAX_TABLES = 64;
  localparam int ENTRIES    = 64;
  localparam int ID_WIDTH   = 32;

  localparam int TBL_ID_W   = 32;
  localparam int IDX_W      = 10;
  localparam int WORD_W     = 64;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;

  localparam int KEY_W   = (ID_WIDTH < TBL_ID_W) ? ID_WIDTH : TBL_ID_W;
  localparam int SLOT_W  = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int COUNT_W = $clog2(MAX_TABLES + 1);
  localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ADDR_W  = SLOT_W + ENTRY_W;
  localparam int WORD_DEPTH = MAX_TABLES * (1 << ENTRY_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_PROBE  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_RANGE     = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_ID    = 3'd4
  } status_t;

  typedef struct packed {
    logic capture;
    logic access;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic mem_op;
  } stat_t;

endpackage

### rtl/kts_ctrl.sv
// Request sequencer for the keyed table store: handshakes and datapath commands.
// Depends on kts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  kts_pkg::stat_t stat,
  output kts_pkg::ctl_t  ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl         = '0;
    ctl.capture = (state == S_IDLE) && in_valid;
    ctl.access  = (state == S_ACCESS);
    ctl.commit  = (state == S_FINISH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (ctl.capture) begin
            state <= stat.mem_op ? S_ACCESS : S_FINISH;
          end
        end
        S_ACCESS: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (ctl.commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `KTS_ASSERT(a_commit_shows_result, clk, rst, ctl.commit |=> out_valid)
  `KTS_ASSERT(a_access_then_finish, clk, rst, ctl.access |=> (state == S_FINISH))
  `KTS_ASSERT(a_ready_after_commit, clk, rst, $rose(in_ready) |-> $past(ctl.commit))

endmodule

### rtl/kts_dp.sv
// Datapath for the keyed table store: id lanes, word and mark memories, result register.
// Depends on kts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kts_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  kts_pkg::ctl_t                   ctl,
  output kts_pkg::stat_t                  stat,
  input  logic [kts_pkg::CMD_W-1:0]       cmd,
  input  logic [kts_pkg::TBL_ID_W-1:0]    tbl_id,
  input  logic [kts_pkg::IDX_W-1:0]       entry_index,
  input  logic [kts_pkg::WORD_W-1:0]      write_value,
  output logic [kts_pkg::STATUS_W-1:0]    status,
  output logic [kts_pkg::WORD_W-1:0]      read_data,
  output logic                            present
);

  localparam logic [kts_pkg::IDX_W:0] IdxLimit = (kts_pkg::IDX_W + 1)'(kts_pkg::ENTRIES);
  localparam logic [kts_pkg::COUNT_W-1:0] CountFull = kts_pkg::COUNT_W'(kts_pkg::MAX_TABLES);

  logic [kts_pkg::KEY_W-1:0]   ids [kts_pkg::MAX_TABLES];
  logic [kts_pkg::COUNT_W-1:0] table_count;
  logic [kts_pkg::WORD_W-1:0]  words [kts_pkg::WORD_DEPTH];
  logic [kts_pkg::ENTRIES-1:0] marks [kts_pkg::MAX_TABLES];

  logic [kts_pkg::KEY_W-1:0]   key;
  logic [kts_pkg::MAX_TABLES-1:0] match;
  logic [kts_pkg::SLOT_W-1:0]  hit_slot;
  logic                        hit;
  logic                        in_range;
  kts_pkg::status_t            status_in;
  logic                        mem_op_in;
  logic                        create_in;
  logic                        present_in;
  logic [kts_pkg::SLOT_W-1:0]  slot_in;

  kts_pkg::cmd_t               req_cmd;
  kts_pkg::status_t            req_status;
  logic [kts_pkg::KEY_W-1:0]   req_key;
  logic [kts_pkg::SLOT_W-1:0]  req_slot;
  logic [kts_pkg::ENTRY_W-1:0] req_idx;
  logic [kts_pkg::WORD_W-1:0]  req_value;
  logic                        req_mem_op;
  logic                        req_create;
  logic                        req_present;

  logic [kts_pkg::WORD_W-1:0]  rd_word;
  logic [kts_pkg::ENTRIES-1:0] rd_row;
  logic [kts_pkg::ENTRIES-1:0] row_bit;
  logic [kts_pkg::ADDR_W-1:0]  word_addr;
  logic                        word_we;
  logic                        row_we;
  logic [kts_pkg::ENTRIES-1:0] row_wdata;
  logic                        is_write;
  logic                        is_read;

  assign key = tbl_id[kts_pkg::KEY_W-1:0];

  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < kts_pkg::MAX_TABLES; i++) begin
      match[i] = (kts_pkg::COUNT_W'(i) < table_count) && (ids[i] == key) && (key != '0);
      if (match[i]) begin
        hit_slot = hit_slot | kts_pkg::SLOT_W'(i);
      end
    end
  end

  assign hit      = |match;
  assign in_range = {1'b0, entry_index} < IdxLimit;

  always_comb begin
    status_in  = kts_pkg::ST_OK;
    mem_op_in  = 1'b0;
    create_in  = 1'b0;
    present_in = hit;
    slot_in    = hit_slot;
    unique case (kts_pkg::cmd_t'(cmd))
      kts_pkg::CMD_CREATE: begin
        slot_in = table_count[kts_pkg::SLOT_W-1:0];
        if (table_count == CountFull) begin
          status_in = kts_pkg::ST_FULL;
        end else if (key == '0 || hit) begin
          status_in = kts_pkg::ST_BAD_ID;
        end else begin
          create_in  = 1'b1;
          present_in = 1'b1;
        end
      end
      kts_pkg::CMD_WRITE, kts_pkg::CMD_READ: begin
        if (!hit) begin
          status_in = kts_pkg::ST_NOT_FOUND;
        end else if (!in_range) begin
          status_in = kts_pkg::ST_RANGE;
        end else begin
          mem_op_in = 1'b1;
        end
      end
      kts_pkg::CMD_PROBE: begin
      end
    endcase
  end

  assign stat.mem_op = mem_op_in;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_cmd     <= kts_pkg::cmd_t'(cmd);
      req_status  <= status_in;
      req_key     <= key;
      req_slot    <= slot_in;
      req_idx     <= entry_index[kts_pkg::ENTRY_W-1:0];
      req_value   <= write_value;
      req_mem_op  <= mem_op_in;
      req_create  <= create_in;
      req_present <= present_in;
    end
  end

  assign is_write  = req_mem_op && (req_cmd == kts_pkg::CMD_WRITE);
  assign is_read   = req_mem_op && (req_cmd == kts_pkg::CMD_READ);
  assign word_addr = {req_slot, req_idx};
  assign word_we   = ctl.commit && is_write;
  assign row_we    = ctl.commit && (is_write || req_create);
  assign row_bit   = kts_pkg::ENTRIES'(1) << req_idx;
  assign row_wdata = req_create ? '0 : (rd_row | row_bit);

  always_ff @(posedge clk) begin
    if (word_we) begin
      words[word_addr] <= req_value;
    end
    if (ctl.access) begin
      rd_word <= words[word_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      marks[req_slot] <= row_wdata;
    end
    if (ctl.access) begin
      rd_row <= marks[req_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && req_create) begin
      ids[req_slot] <= req_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_count <= '0;
    end else if (ctl.commit && req_create) begin
      table_count <= table_count + kts_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status    <= req_status;
      present   <= req_present;
      read_data <= (is_read && rd_row[req_idx]) ? rd_word : '0;
    end
  end

  `KTS_NEVER(a_count_bound, clk, rst, table_count > CountFull)
  `KTS_NEVER(a_no_word_write_on_create, clk, rst, word_we && req_create)
  `KTS_ASSERT(a_create_grows, clk, rst, (ctl.commit && req_create) |=> (table_count != $past(table_count)))

endmodule

### rtl/keyed_table_store.sv
// Keyed table store, top level: joins the request sequencer and the datapath.
// Depends on kts_pkg, kts_ctrl and kts_dp.
//
// Holds up to kts_pkg::MAX_TABLES tables of kts_pkg::ENTRIES 64-bit words, each named by a
// nonzero id; one result per request. The id compare against all created tables runs in
// the accept cycle. Create, probe and every rejected request go from accept straight to the
// finish state; an accepted read or write first passes the access state, the registered
// read of the word memory and the per-table written-mark row, which a write then updates in
// the result cycle. A new request is taken in the cycle after the result is registered,
// even while that result still waits on out_ready; the next result then holds until the
// output register frees. Words never written read as zero: each table's mark row is cleared
// when the table is created, so no clearing pass runs after reset.
`timescale 1ns / 1ps

module keyed_table_store (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kts_pkg::CMD_W-1:0]       cmd,
  input  logic [kts_pkg::TBL_ID_W-1:0]    tbl_id,
  input  logic [kts_pkg::IDX_W-1:0]       entry_index,
  input  logic [kts_pkg::WORD_W-1:0]      write_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kts_pkg::STATUS_W-1:0]    status,
  output logic [kts_pkg::WORD_W-1:0]      read_data,
  output logic                            present
);

  kts_pkg::ctl_t  ctl;
  kts_pkg::stat_t stat;

  kts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  kts_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cmd         (cmd),
    .tbl_id      (tbl_id),
    .entry_index (entry_index),
    .write_value (write_value),
    .status      (status),
    .read_data   (read_data),
    .present     (present)
  );

endmodule

### test/tb.sv
// Self-checking testbench for keyed_table_store: a scoreboard class predicts every result
// and checks each one in order, while plain tasks drive requests. Depends on kts_pkg.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [kts_pkg::STATUS_W-1:0] st;
    logic [kts_pkg::WORD_W-1:0]   data;
    logic                         pres;
  } table_result_t;

  class table_scoreboard;
    logic [kts_pkg::TBL_ID_W-1:0] ids [kts_pkg::MAX_TABLES];
    int                           count;
    logic [kts_pkg::WORD_W-1:0]   words [kts_pkg::MAX_TABLES][kts_pkg::ENTRIES];
    bit                           marks [kts_pkg::MAX_TABLES][kts_pkg::ENTRIES];
    table_result_t                pending_results [$];
    int                           errors;
    int                           checked;
    int                           full_hits;

    function int find_slot(logic [kts_pkg::TBL_ID_W-1:0] id);
      if (id == '0) return -1;
      for (int i = 0; i < count; i++)
        if (ids[i] == id) return i;
      return -1;
    endfunction

    function void note_request(kts_pkg::cmd_t c, logic [kts_pkg::TBL_ID_W-1:0] id,
                               logic [kts_pkg::IDX_W-1:0] idx,
                               logic [kts_pkg::WORD_W-1:0] val);
      int            slot;
      table_result_t r;
      slot   = find_slot(id);
      r.st   = kts_pkg::ST_OK;
      r.data = '0;
      case (c)
        kts_pkg::CMD_CREATE: begin
          if (count >= kts_pkg::MAX_TABLES) begin
            r.st = kts_pkg::ST_FULL;
            full_hits++;
          end else if (id == '0 || slot >= 0) begin
            r.st = kts_pkg::ST_BAD_ID;
          end else begin
            ids[count] = id;
            for (int e = 0; e < kts_pkg::ENTRIES; e++) marks[count][e] = 1'b0;
            slot = count;
            count++;
          end
        end
        kts_pkg::CMD_WRITE, kts_pkg::CMD_READ: begin
          if (slot < 0) begin
            r.st = kts_pkg::ST_NOT_FOUND;
          end else if (idx >= kts_pkg::ENTRIES) begin
            r.st = kts_pkg::ST_RANGE;
          end else if (c == kts_pkg::CMD_WRITE) begin
            words[slot][idx] = val;
            marks[slot][idx] = 1'b1;
          end else begin
            r.data = marks[slot][idx] ? words[slot][idx] : '0;
          end
        end
        default: ;
      endcase
      r.pres = (slot >= 0);
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [kts_pkg::STATUS_W-1:0] st, logic [kts_pkg::WORD_W-1:0] data,
                      logic pres);
      table_result_t e;
      checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        e = pending_results.pop_front();
        if (st !== e.st)
          report_mismatch($sformatf("status %0d, expected %0d", st, e.st));
        if (data !== e.data)
          report_mismatch($sformatf("read_data %h, expected %h", data, e.data));
        if (pres !== e.pres)
          report_mismatch($sformatf("present %b, expected %b", pres, e.pres));
      end
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [kts_pkg::CMD_W-1:0]    cmd = '0;
  logic [kts_pkg::TBL_ID_W-1:0] tbl_id = '0;
  logic [kts_pkg::IDX_W-1:0]    entry_index = '0;
  logic [kts_pkg::WORD_W-1:0]   write_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [kts_pkg::STATUS_W-1:0] status;
  logic [kts_pkg::WORD_W-1:0]   read_data;
  logic                         present;

  table_scoreboard sb = new();
  bit              sender_burst;
  bit              receiver_burst;
  int              sent;

  keyed_table_store i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .tbl_id      (tbl_id),
    .entry_index (entry_index),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_data   (read_data),
    .present     (present)
  );

  always #1 clk = ~clk;

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input kts_pkg::cmd_t c, input logic [kts_pkg::TBL_ID_W-1:0] id,
                              input logic [kts_pkg::IDX_W-1:0] idx,
                              input logic [kts_pkg::WORD_W-1:0] val);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    tbl_id      <= id;
    entry_index <= idx;
    write_value <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_request(c, id, idx, val);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [kts_pkg::TBL_ID_W-1:0] fresh_id();
    logic [kts_pkg::TBL_ID_W-1:0] id;
    do id = $urandom; while (id == '0 || sb.find_slot(id) >= 0);
    return id;
  endfunction

  function automatic logic [kts_pkg::TBL_ID_W-1:0] known_id();
    return sb.ids[$urandom_range(0, sb.count - 1)];
  endfunction

  function automatic logic [kts_pkg::WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [kts_pkg::IDX_W-1:0] rand_idx();
    return kts_pkg::IDX_W'($urandom);
  endfunction

  task automatic send_random();
    int                           r;
    int                           s;
    bit                           found;
    logic [kts_pkg::TBL_ID_W-1:0] id;
    logic [kts_pkg::IDX_W-1:0]    idx;
    r   = $urandom_range(0, 99);
    idx = kts_pkg::IDX_W'($urandom_range(0, kts_pkg::ENTRIES - 1));
    if ($urandom_range(0, 9) == 0) idx = rand_idx();
    if (sb.count > 0 && $urandom_range(0, 9) != 0) id = known_id();
    else id = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
    if (r < 7) begin
      s = $urandom_range(0, 9);
      if (s < 7 || sb.count == 0) id = (s == 9) ? '0 : fresh_id();
      else if (s < 9) id = known_id();
      else id = '0;
      send_request(kts_pkg::CMD_CREATE, id, rand_idx(), rand_word());
    end else if (r < 45) begin
      send_request(kts_pkg::CMD_WRITE, id, idx, rand_word());
    end else if (r < 82) begin
      // Read a written word of a known table if one is found, else write one; other ids read as drawn.
      found = 1'b0;
      s = sb.find_slot(id);
      if (s >= 0 && idx < kts_pkg::ENTRIES) begin
        for (int k = 0; k < 8 && !found; k++) begin
          if (sb.marks[s][idx]) found = 1'b1;
          else idx = kts_pkg::IDX_W'($urandom_range(0, kts_pkg::ENTRIES - 1));
        end
        if (found) send_request(kts_pkg::CMD_READ, id, idx, rand_word());
        else send_request(kts_pkg::CMD_WRITE, id, idx, rand_word());
      end else begin
        send_request(kts_pkg::CMD_READ, id, idx, rand_word());
      end
    end else begin
      send_request(kts_pkg::CMD_PROBE, id, rand_idx(), rand_word());
    end
  endtask

  // Sender
  initial begin
    logic [kts_pkg::TBL_ID_W-1:0] id;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_request(kts_pkg::CMD_PROBE,  '0,           10'd0,    '0);
    send_request(kts_pkg::CMD_READ,   32'd5,        10'd0,    '0);
    send_request(kts_pkg::CMD_WRITE,  '0,           10'd0,    '1);
    send_request(kts_pkg::CMD_CREATE, '0,           10'd0,    '0);
    send_request(kts_pkg::CMD_CREATE, 32'hFFFFFFFF, 10'd0,    '0);
    send_request(kts_pkg::CMD_CREATE, 32'h00000001, 10'd1023, '1);
    send_request(kts_pkg::CMD_CREATE, 32'hFFFFFFFF, 10'd0,    '0);
    send_request(kts_pkg::CMD_WRITE,  32'hFFFFFFFF, 10'd0,    '1);
    send_request(kts_pkg::CMD_WRITE,  32'h00000001, 10'd63,   64'h8000_0000_0000_0001);
    send_request(kts_pkg::CMD_READ,   32'hFFFFFFFF, 10'd0,    '0);
    send_request(kts_pkg::CMD_READ,   32'h00000001, 10'd63,   '1);
    send_request(kts_pkg::CMD_WRITE,  32'h00000001, 10'd64,   '1);
    send_request(kts_pkg::CMD_READ,   32'h00000001, 10'd1023, '0);
    send_request(kts_pkg::CMD_WRITE,  32'h00000002, 10'd0,    '1);
    send_request(kts_pkg::CMD_READ,   32'h00000002, 10'd0,    '0);
    send_request(kts_pkg::CMD_PROBE,  32'h00000001, 10'd0,    '0);
    send_request(kts_pkg::CMD_PROBE,  32'h00000002, 10'd0,    '0);
    send_request(kts_pkg::CMD_WRITE,  32'hFFFFFFFF, 10'd0,    '0);
    send_request(kts_pkg::CMD_READ,   32'hFFFFFFFF, 10'd0,    '1);
    send_request(kts_pkg::CMD_WRITE,  32'h00000001, 10'd0,    64'hA5A5_5A5A_0FF0_F00F);
    send_request(kts_pkg::CMD_READ,   32'h00000001, 10'd0,    '0);
    for (int n = 0; n < 1300; n++) begin
      if (n % 50 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      send_random();
    end
    // Fill the list, then hit it with every kind of create.
    while (sb.count < kts_pkg::MAX_TABLES)
      send_request(kts_pkg::CMD_CREATE, fresh_id(), rand_idx(), rand_word());
    send_request(kts_pkg::CMD_CREATE, fresh_id(), 10'd0, '0);
    send_request(kts_pkg::CMD_CREATE, '0, 10'd0, '0);
    send_request(kts_pkg::CMD_CREATE, known_id(), 10'd0, '0);
    id = sb.ids[kts_pkg::MAX_TABLES - 1];
    send_request(kts_pkg::CMD_WRITE, id, 10'd5, 64'h0123_4567_89AB_CDEF);
    send_request(kts_pkg::CMD_READ,  id, 10'd5, '0);
    send_request(kts_pkg::CMD_PROBE, id, 10'd0, '0);
    for (int n = 0; n < 30; n++) send_random();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d requests and %0d results; %0d tables created,", sent, sb.checked,
             sb.count);
    $display("%0d creates on a full list, and a long output stall.", sb.full_hits);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Receiver
  initial begin
    int gap;
    int results;
    results = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (results % 50 == 0) receiver_burst = ($urandom_range(0, 3) == 0);
      gap = receiver_burst ? 0 : $urandom_range(0, 5);
      // Hold off long enough for the block to back up into its input.
      if (results == 300) gap = 200;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(status, read_data, present);
      results++;
    end
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
